// ===== hw/rtl/ramt_pkg.sv =====
`timescale 1ns / 1ps

package ramt_pkg;

    // default sizing
    localparam int DEF_MAX_ELEMENTS = 4096;
    localparam int DEF_BLOCK_SIZE   = 64;

    // fixed field widths
    localparam int VAL_W   = 31;
    localparam int CNT_W   = 13;
    localparam int START_W = 12;
    localparam int CFG_IDX_W = 2;

    // reset values of the configuration registers
    localparam int RST_ELEMENT_COUNT = 4096;
    localparam logic [VAL_W-1:0] RST_INITIAL_VALUE = 31'h7FFF_FFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VALUE = 2'd1;

    // item modes
    localparam logic MODE_ASSIGN = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // one block record
    typedef struct packed {
        logic [VAL_W-1:0] min_val;
        logic [VAL_W-1:0] pend_val;
        logic             pend;
    } rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REC_EV,
        ST_WALK,
        ST_REC_WB,
        ST_FINISH
    } state_t;

endpackage

// ===== hw/rtl/ramt_rec_mem.sv =====
`timescale 1ns / 1ps

module ramt_rec_mem #(
    parameter int NUM_BLOCKS = 64,
    parameter int BW = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clr,
    input  logic                  rd_en,
    input  logic [BW-1:0]         rd_addr,
    output ramt_pkg::rec_t        rd_data,
    output logic                  rd_valid,
    input  logic                  wr_en,
    input  logic [BW-1:0]         wr_addr,
    input  ramt_pkg::rec_t        wr_data
);

    ramt_pkg::rec_t          mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]   valid_reg;
    ramt_pkg::rec_t          rd_data_reg;
    logic                    rd_valid_reg;

    // record storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // per-entry valid bits, a cleared entry reads as pending at the initial value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr] & ~clr;
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// ===== hw/rtl/ramt_elem_mem.sv =====
`timescale 1ns / 1ps

module ramt_elem_mem #(
    parameter int DEPTH = 4096,
    parameter int AW = 12
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [ramt_pkg::VAL_W-1:0]  rd_data,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [ramt_pkg::VAL_W-1:0]  wr_data
);

    logic [ramt_pkg::VAL_W-1:0] mem [DEPTH];
    logic [ramt_pkg::VAL_W-1:0] rd_data_reg;

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/ramt_ctrl.sv =====
`timescale 1ns / 1ps

module ramt_ctrl #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int BLOCK_SIZE = 64,
    parameter int NUM_BLOCKS = 64,
    parameter int BW = 6,
    parameter int AW = 12,
    parameter int PW = 14,
    parameter int STORE_LEN = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [ramt_pkg::START_W-1:0]    range_start,
    input  logic [ramt_pkg::CNT_W-1:0]      range_end,
    input  logic [ramt_pkg::VAL_W-1:0]      new_value,
    // output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ramt_pkg::VAL_W-1:0]      range_min,
    // configuration
    input  logic                            cfg_we,
    input  logic [ramt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ramt_pkg::VAL_W-1:0]      cfg_data,
    output logic                            rec_clr,
    // block record memory
    output logic                            rec_rd_en,
    output logic [BW-1:0]                   rec_rd_addr,
    input  ramt_pkg::rec_t                  rec_rd_data,
    input  logic                            rec_rd_valid,
    output logic                            rec_wr_en,
    output logic [BW-1:0]                   rec_wr_addr,
    output ramt_pkg::rec_t                  rec_wr_data,
    // element memory
    output logic                            el_rd_en,
    output logic [AW-1:0]                   el_rd_addr,
    input  logic [ramt_pkg::VAL_W-1:0]      el_rd_data,
    output logic                            el_wr_en,
    output logic [AW-1:0]                   el_wr_addr,
    output logic [ramt_pkg::VAL_W-1:0]      el_wr_data
);

    localparam int JW = $clog2(BLOCK_SIZE + 1);
    localparam int RST_CNT = (MAX_ELEMENTS < ramt_pkg::RST_ELEMENT_COUNT) ?
                             MAX_ELEMENTS : ramt_pkg::RST_ELEMENT_COUNT;

    ramt_pkg::state_t state_reg, state_next;

    logic                            mode_reg, mode_next;
    logic [PW-1:0]                   s_reg, s_next;
    logic [PW-1:0]                   tc_reg, tc_next;
    logic [ramt_pkg::VAL_W-1:0]      x_reg, x_next;
    logic [BW-1:0]                   b_reg, b_next;
    logic [PW-1:0]                   l_reg, l_next;
    logic [JW-1:0]                   j_reg, j_next;
    logic                            p_v_reg, p_v_next;
    logic [PW-1:0]                   p_g_reg, p_g_next;
    logic [ramt_pkg::VAL_W-1:0]      m_reg, m_next;
    logic [ramt_pkg::VAL_W-1:0]      res_reg, res_next;
    logic                            out_valid_reg, out_valid_next;
    logic [ramt_pkg::VAL_W-1:0]      range_min_reg, range_min_next;
    logic [ramt_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [ramt_pkg::VAL_W-1:0]      init_reg, init_next;

    logic                            in_beat;
    logic [ramt_pkg::CNT_W-1:0]      end_clamped;
    logic [PW-1:0]                   r_cur;
    logic                            full_blk;
    logic                            last_blk;
    logic                            out_free;
    ramt_pkg::rec_t                  rec_cur;
    logic [ramt_pkg::VAL_W-1:0]      el_val;
    logic                            el_in_range;
    logic [PW-1:0]                   walk_addr;

    assign in_ready   = (state_reg == ramt_pkg::ST_IDLE);
    assign in_beat    = in_valid & in_ready;
    assign out_valid  = out_valid_reg;
    assign range_min  = range_min_reg;
    assign rec_clr    = cfg_we & ((cfg_index == ramt_pkg::REG_ELEMENT_COUNT) ||
                                  (cfg_index == ramt_pkg::REG_INITIAL_VALUE));

    // block geometry of the current block
    assign end_clamped = (range_end > count_reg) ? count_reg : range_end;
    assign r_cur       = l_reg + PW'(BLOCK_SIZE);
    assign full_blk    = (s_reg <= l_reg) && (r_cur <= tc_reg);
    assign last_blk    = (b_reg == BW'(NUM_BLOCKS - 1)) || (r_cur >= tc_reg);
    assign out_free    = ~out_valid_reg | out_ready;

    // a record never written reads as pending at the initial value
    always_comb
    begin
        if (rec_rd_valid)
        begin
            rec_cur = rec_rd_data;
        end
        else
        begin
            rec_cur.min_val  = init_reg;
            rec_cur.pend_val = init_reg;
            rec_cur.pend     = 1'b1;
        end
    end

    // element walk values
    assign walk_addr   = l_reg + PW'(j_reg);
    assign el_in_range = (p_g_reg >= s_reg) && (p_g_reg < tc_reg);
    always_comb
    begin
        el_val = rec_cur.pend ? rec_cur.pend_val : el_rd_data;
        if ((mode_reg == ramt_pkg::MODE_ASSIGN) && el_in_range)
        begin
            el_val = x_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ramt_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (PW'(range_start) < PW'(end_clamped))
                    begin
                        state_next = ramt_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = ramt_pkg::ST_FINISH;
                    end
                end
            end
            ramt_pkg::ST_SCAN:
            begin
                if (l_reg >= tc_reg)
                begin
                    state_next = ramt_pkg::ST_FINISH;
                end
                else if (r_cur > s_reg)
                begin
                    state_next = ramt_pkg::ST_REC_EV;
                end
            end
            ramt_pkg::ST_REC_EV:
            begin
                if (!full_blk)
                begin
                    state_next = ramt_pkg::ST_WALK;
                end
                else if (last_blk)
                begin
                    state_next = ramt_pkg::ST_FINISH;
                end
            end
            ramt_pkg::ST_WALK:
            begin
                if (j_reg == JW'(BLOCK_SIZE))
                begin
                    state_next = ramt_pkg::ST_REC_WB;
                end
            end
            ramt_pkg::ST_REC_WB:
            begin
                if (last_blk)
                begin
                    state_next = ramt_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = ramt_pkg::ST_REC_EV;
                end
            end
            ramt_pkg::ST_FINISH:
            begin
                if ((mode_reg == ramt_pkg::MODE_ASSIGN) || out_free)
                begin
                    state_next = ramt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ramt_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        mode_next      = mode_reg;
        s_next         = s_reg;
        tc_next        = tc_reg;
        x_next         = x_reg;
        b_next         = b_reg;
        l_next         = l_reg;
        j_next         = j_reg;
        p_v_next       = 1'b0;
        p_g_next       = p_g_reg;
        m_next         = m_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        range_min_next = range_min_reg;
        count_next     = count_reg;
        init_next      = init_reg;

        rec_rd_en   = 1'b0;
        rec_rd_addr = b_reg;
        rec_wr_en   = 1'b0;
        rec_wr_addr = b_reg;
        rec_wr_data = rec_cur;
        el_rd_en    = 1'b0;
        el_rd_addr  = walk_addr[AW-1:0];
        el_wr_en    = 1'b0;
        el_wr_addr  = p_g_reg[AW-1:0];
        el_wr_data  = el_val;

        // result register drains independently
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_we)
        begin
            if (cfg_index == ramt_pkg::REG_ELEMENT_COUNT)
            begin
                if (32'(cfg_data[ramt_pkg::CNT_W-1:0]) > 32'(MAX_ELEMENTS))
                begin
                    count_next = ramt_pkg::CNT_W'(MAX_ELEMENTS);
                end
                else
                begin
                    count_next = cfg_data[ramt_pkg::CNT_W-1:0];
                end
            end
            else if (cfg_index == ramt_pkg::REG_INITIAL_VALUE)
            begin
                init_next = cfg_data;
            end
        end

        case (state_reg)
            ramt_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    mode_next = mode;
                    s_next    = PW'(range_start);
                    tc_next   = PW'(end_clamped);
                    x_next    = new_value;
                    b_next    = '0;
                    l_next    = '0;
                    res_next  = init_reg;
                end
            end
            ramt_pkg::ST_SCAN:
            begin
                // skip blocks wholly before the range, else fetch the record
                if (l_reg < tc_reg)
                begin
                    if (r_cur <= s_reg)
                    begin
                        b_next = b_reg + BW'(1);
                        l_next = r_cur;
                    end
                    else
                    begin
                        rec_rd_en = 1'b1;
                    end
                end
            end
            ramt_pkg::ST_REC_EV:
            begin
                if (full_blk)
                begin
                    // covered block handled through its record
                    if (mode_reg == ramt_pkg::MODE_ASSIGN)
                    begin
                        rec_wr_en            = 1'b1;
                        rec_wr_data.min_val  = x_reg;
                        rec_wr_data.pend_val = x_reg;
                        rec_wr_data.pend     = 1'b1;
                    end
                    else if (rec_cur.min_val < res_reg)
                    begin
                        res_next = rec_cur.min_val;
                    end
                    if (!last_blk)
                    begin
                        b_next      = b_reg + BW'(1);
                        l_next      = r_cur;
                        rec_rd_en   = 1'b1;
                        rec_rd_addr = b_reg + BW'(1);
                    end
                end
                else
                begin
                    j_next = '0;
                    m_next = init_reg;
                end
            end
            ramt_pkg::ST_WALK:
            begin
                // issue the next element read
                if (j_reg != JW'(BLOCK_SIZE))
                begin
                    el_rd_en = 1'b1;
                    p_v_next = 1'b1;
                    p_g_next = walk_addr;
                    j_next   = j_reg + JW'(1);
                end
                // process the element read last cycle
                if (p_v_reg)
                begin
                    el_wr_en = (mode_reg == ramt_pkg::MODE_ASSIGN) | rec_cur.pend;
                    if ((mode_reg == ramt_pkg::MODE_ASSIGN) && (el_val < m_reg))
                    begin
                        m_next = el_val;
                    end
                    if ((mode_reg == ramt_pkg::MODE_QUERY) && el_in_range &&
                        (el_val < res_reg))
                    begin
                        res_next = el_val;
                    end
                end
            end
            ramt_pkg::ST_REC_WB:
            begin
                // partial block is flushed, assign refreshes its minimum
                rec_wr_en        = 1'b1;
                rec_wr_data.pend = 1'b0;
                if (mode_reg == ramt_pkg::MODE_ASSIGN)
                begin
                    rec_wr_data.min_val = m_reg;
                end
                if (!last_blk)
                begin
                    b_next      = b_reg + BW'(1);
                    l_next      = r_cur;
                    rec_rd_en   = 1'b1;
                    rec_rd_addr = b_reg + BW'(1);
                end
            end
            ramt_pkg::ST_FINISH:
            begin
                if ((mode_reg == ramt_pkg::MODE_QUERY) && out_free)
                begin
                    out_valid_next = 1'b1;
                    range_min_next = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ramt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            p_v_reg       <= 1'b0;
            count_reg     <= ramt_pkg::CNT_W'(RST_CNT);
            init_reg      <= ramt_pkg::RST_INITIAL_VALUE;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            p_v_reg       <= p_v_next;
            count_reg     <= count_next;
            init_reg      <= init_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        s_reg         <= s_next;
        tc_reg        <= tc_next;
        x_reg         <= x_next;
        b_reg         <= b_next;
        l_reg         <= l_next;
        j_reg         <= j_next;
        p_g_reg       <= p_g_next;
        m_reg         <= m_next;
        res_reg       <= res_next;
        range_min_reg <= range_min_next;
    end

    // a result never exceeds the initial value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (range_min_reg <= init_reg))
        else $error("range_min above initial value");

    // record read and write never hit the same entry in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (rec_rd_en && rec_wr_en) |-> (rec_rd_addr != rec_wr_addr))
        else $error("record read and write collide");

    // element writes stay inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        el_wr_en |-> (p_g_reg < PW'(STORE_LEN)))
        else $error("element write out of store");

    // the walk starts with an empty read pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ramt_pkg::ST_REC_EV) |=> !p_v_reg)
        else $error("stale element in walk pipeline");

endmodule

// ===== hw/rtl/range_assign_range_min_table_core.sv =====
`timescale 1ns / 1ps

// Range assign / range minimum table over up to MAX_ELEMENTS values split
// into blocks of BLOCK_SIZE. One item at a time: after the input beat the
// sequencer skips the blocks ahead of the range one by one, handles each
// fully covered block through its record alone (block record memory, one
// read and one write a cycle) and handles each partially covered block by
// a record check, a pipelined walk over its BLOCK_SIZE elements and a record
// write back, then finishes; an empty range goes straight to the finish. A
// query delivers one range_min beat; an assign delivers none. The output
// register lets the next item in while a result waits. No clearing pass
// follows reset.

module range_assign_range_min_table_core #(
    parameter int MAX_ELEMENTS = ramt_pkg::DEF_MAX_ELEMENTS,
    parameter int BLOCK_SIZE = ramt_pkg::DEF_BLOCK_SIZE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [ramt_pkg::START_W-1:0]    range_start,
    input  logic [ramt_pkg::CNT_W-1:0]      range_end,
    input  logic [ramt_pkg::VAL_W-1:0]      new_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ramt_pkg::VAL_W-1:0]      range_min,
    input  logic                            cfg_we,
    input  logic [ramt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ramt_pkg::VAL_W-1:0]      cfg_data
);

    localparam int NUM_BLOCKS = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int STORE_LEN  = NUM_BLOCKS * BLOCK_SIZE;
    localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int AW = $clog2(STORE_LEN);
    localparam int PW_RAW = $clog2(STORE_LEN + BLOCK_SIZE + 1);
    localparam int PW = (PW_RAW > ramt_pkg::CNT_W) ? PW_RAW : ramt_pkg::CNT_W;

    logic                        rec_clr;
    logic                        rec_rd_en;
    logic [BW-1:0]               rec_rd_addr;
    ramt_pkg::rec_t              rec_rd_data;
    logic                        rec_rd_valid;
    logic                        rec_wr_en;
    logic [BW-1:0]               rec_wr_addr;
    ramt_pkg::rec_t              rec_wr_data;
    logic                        el_rd_en;
    logic [AW-1:0]               el_rd_addr;
    logic [ramt_pkg::VAL_W-1:0]  el_rd_data;
    logic                        el_wr_en;
    logic [AW-1:0]               el_wr_addr;
    logic [ramt_pkg::VAL_W-1:0]  el_wr_data;

    // sequencer
    ramt_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .BLOCK_SIZE   (BLOCK_SIZE),
        .NUM_BLOCKS   (NUM_BLOCKS),
        .BW           (BW),
        .AW           (AW),
        .PW           (PW),
        .STORE_LEN    (STORE_LEN)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .range_start  (range_start),
        .range_end    (range_end),
        .new_value    (new_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .range_min    (range_min),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rec_clr      (rec_clr),
        .rec_rd_en    (rec_rd_en),
        .rec_rd_addr  (rec_rd_addr),
        .rec_rd_data  (rec_rd_data),
        .rec_rd_valid (rec_rd_valid),
        .rec_wr_en    (rec_wr_en),
        .rec_wr_addr  (rec_wr_addr),
        .rec_wr_data  (rec_wr_data),
        .el_rd_en     (el_rd_en),
        .el_rd_addr   (el_rd_addr),
        .el_rd_data   (el_rd_data),
        .el_wr_en     (el_wr_en),
        .el_wr_addr   (el_wr_addr),
        .el_wr_data   (el_wr_data)
    );

    // block records
    ramt_rec_mem #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .BW         (BW)
    ) u_rec_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (rec_clr),
        .rd_en    (rec_rd_en),
        .rd_addr  (rec_rd_addr),
        .rd_data  (rec_rd_data),
        .rd_valid (rec_rd_valid),
        .wr_en    (rec_wr_en),
        .wr_addr  (rec_wr_addr),
        .wr_data  (rec_wr_data)
    );

    // element store
    ramt_elem_mem #(
        .DEPTH (STORE_LEN),
        .AW    (AW)
    ) u_elem_mem (
        .clk     (clk),
        .rd_en   (el_rd_en),
        .rd_addr (el_rd_addr),
        .rd_data (el_rd_data),
        .wr_en   (el_wr_en),
        .wr_addr (el_wr_addr),
        .wr_data (el_wr_data)
    );

endmodule
